// File: rtl/pgmd_pkg.sv
// Shared types and constants for the binary gray map stream deframer.
// No dependencies; used by the top level, the checker and the testbench.
package pgmd_pkg;

  // Default number of bits for the image width and height.
  localparam int PGMD_DIM_BITS = 16;

  // Width of the error code field on the result channel.
  localparam int PGMD_ERR_BITS = 3;

  // Error codes reported on the result channel.
  typedef enum logic [PGMD_ERR_BITS-1:0] {
    ERR_NONE       = 3'd0,
    ERR_LEAD_SPACE = 3'd1,
    ERR_BAD_MAGIC  = 3'd2,
    ERR_NON_DIGIT  = 3'd3,
    ERR_TOO_LARGE  = 3'd4,
    ERR_EARLY_EOF  = 3'd5
  } pgmd_err_t;

  // Characters of the magic token.
  localparam logic [7:0] MAGIC_UPPER_P = 8'h50;
  localparam logic [7:0] MAGIC_LOWER_P = 8'h70;
  localparam logic [7:0] MAGIC_FIVE    = 8'h35;

endpackage

// File: rtl/pgm_binary_stream_deframer.sv
// Top level of the binary gray map (P5) stream deframer.
// Depends on pgmd_pkg and pgmd_digit_acc.

// One byte or end-of-file mark is taken per item and every item yields exactly
// one result item. The block accepts a new item in every cycle, also while a
// result waits, as long as out_ready takes the pending result; a result appears
// in the cycle after its item is accepted. All parsing state is updated in a
// single pass at the accepting clock edge, the longest path being the
// constant-ten multiply-add of the decimal accumulator, and the result sits in
// one output register. The header (magic P5 or p5, width, height, maximum gray)
// is checked on the fly; pixels are then passed through with a last-pixel mark.
// Once all pixels arrived, an empty image's header ended or an error latched,
// finished stays high and the stored header values are repeated with no pulses.
module pgm_binary_stream_deframer import pgmd_pkg::*; #(
  parameter int DIM_BITS = PGMD_DIM_BITS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [7:0]               in_data_byte,
  input  logic                     in_end_of_file,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     out_pixel_valid,
  output logic [7:0]               out_pixel_value,
  output logic                     out_last_pixel,
  output logic                     out_header_done,
  output logic [15:0]              out_image_width,
  output logic [15:0]              out_image_height,
  output logic [7:0]               out_max_gray,
  output logic [PGMD_ERR_BITS-1:0] out_error_code,
  output logic                     out_finished
);

  typedef enum logic [3:0] {
    PH_MAGIC0, PH_MAGIC, PH_GAP_W, PH_NUM_W, PH_GAP_H,
    PH_NUM_H, PH_GAP_G, PH_NUM_G, PH_PIXELS, PH_DONE
  } phase_t;

  // Parser state.
  phase_t              phase_r, phase_nxt;
  logic [1:0]          mlen_r, mlen_nxt;
  logic [7:0]          mfirst_r, mfirst_nxt;
  logic [7:0]          msecond_r, msecond_nxt;
  logic [DIM_BITS:0]   acc_r, acc_nxt;
  logic                dend_r, dend_nxt;
  logic [DIM_BITS-1:0] width_r, width_nxt;
  logic [DIM_BITS-1:0] height_r, height_nxt;
  logic [7:0]          gray_r, gray_nxt;
  logic [DIM_BITS-1:0] col_r, col_nxt;
  logic [DIM_BITS-1:0] row_r, row_nxt;
  pgmd_err_t           err_r, err_nxt;

  // Result register.
  logic                out_valid_r;
  logic                pv_r, pv_nxt;
  logic [7:0]          pval_r, pval_nxt;
  logic                last_r, last_nxt;
  logic                hd_r, hd_nxt;
  logic [15:0]         owidth_r;
  logic [15:0]         oheight_r;
  logic [7:0]          ogray_r;
  pgmd_err_t           oerr_r;
  logic                ofin_r;

  logic                accept;
  logic                is_ws;
  logic                is_dig;
  logic [DIM_BITS:0]   acc_step;
  logic [DIM_BITS:0]   col_inc;
  logic [DIM_BITS:0]   row_inc;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  // Whitespace is tab through carriage return, and space.
  assign is_ws  = (in_data_byte == 8'd32) ||
                  ((in_data_byte >= 8'd9) && (in_data_byte <= 8'd13));
  assign is_dig = (in_data_byte >= 8'h30) && (in_data_byte <= 8'h39);

  pgmd_digit_acc #(
    .DIM_BITS(DIM_BITS)
  ) u_acc (
    .acc_cur (acc_r),
    .digit   (in_data_byte[3:0]),
    .acc_new (acc_step)
  );

  assign col_inc = {1'b0, col_r} + {{DIM_BITS{1'b0}}, 1'b1};
  assign row_inc = {1'b0, row_r} + {{DIM_BITS{1'b0}}, 1'b1};

  // Next-state logic for one accepted item.
  always_comb begin
    phase_nxt   = phase_r;
    mlen_nxt    = mlen_r;
    mfirst_nxt  = mfirst_r;
    msecond_nxt = msecond_r;
    acc_nxt     = acc_r;
    dend_nxt    = dend_r;
    width_nxt   = width_r;
    height_nxt  = height_r;
    gray_nxt    = gray_r;
    col_nxt     = col_r;
    row_nxt     = row_r;
    err_nxt     = err_r;
    pv_nxt      = 1'b0;
    pval_nxt    = 8'd0;
    last_nxt    = 1'b0;
    hd_nxt      = 1'b0;

    if (phase_r != PH_DONE) begin
      if (in_end_of_file) begin
        err_nxt   = ERR_EARLY_EOF;
        phase_nxt = PH_DONE;
      end else begin
        case (phase_r)
          PH_MAGIC0: begin
            if (is_ws) begin
              err_nxt   = ERR_LEAD_SPACE;
              phase_nxt = PH_DONE;
            end else begin
              mfirst_nxt = in_data_byte;
              mlen_nxt   = 2'd1;
              phase_nxt  = PH_MAGIC;
            end
          end
          PH_MAGIC: begin
            if (!is_ws) begin
              if (mlen_r == 2'd1) begin
                msecond_nxt = in_data_byte;
              end
              if (mlen_r != 2'd3) begin
                mlen_nxt = mlen_r + 2'd1;
              end
            end else if ((mlen_r == 2'd2) &&
                         ((mfirst_r == MAGIC_UPPER_P) || (mfirst_r == MAGIC_LOWER_P)) &&
                         (msecond_r == MAGIC_FIVE)) begin
              phase_nxt = PH_GAP_W;
            end else begin
              err_nxt   = ERR_BAD_MAGIC;
              phase_nxt = PH_DONE;
            end
          end
          PH_GAP_W, PH_GAP_H, PH_GAP_G: begin
            // A token must open with a digit.
            if (!is_ws) begin
              if (!is_dig) begin
                err_nxt   = ERR_NON_DIGIT;
                phase_nxt = PH_DONE;
              end else begin
                acc_nxt  = (DIM_BITS+1)'(in_data_byte[3:0]);
                dend_nxt = 1'b0;
                case (phase_r)
                  PH_GAP_W: phase_nxt = PH_NUM_W;
                  PH_GAP_H: phase_nxt = PH_NUM_H;
                  default:  phase_nxt = PH_NUM_G;
                endcase
              end
            end
          end
          PH_NUM_W, PH_NUM_H, PH_NUM_G: begin
            if (!is_ws) begin
              // Trailing junk after the digits is ignored up to whitespace.
              if (dend_r || !is_dig) begin
                dend_nxt = 1'b1;
              end else begin
                acc_nxt = acc_step;
              end
            end else if (phase_r == PH_NUM_G) begin
              if (|acc_r[DIM_BITS:8]) begin
                err_nxt   = ERR_TOO_LARGE;
                phase_nxt = PH_DONE;
              end else begin
                gray_nxt  = acc_r[7:0];
                hd_nxt    = 1'b1;
                col_nxt   = '0;
                row_nxt   = '0;
                // An empty image finishes with the header.
                phase_nxt = ((width_r == '0) || (height_r == '0)) ? PH_DONE : PH_PIXELS;
              end
            end else if (acc_r[DIM_BITS]) begin
              err_nxt   = ERR_TOO_LARGE;
              phase_nxt = PH_DONE;
            end else if (phase_r == PH_NUM_W) begin
              width_nxt = acc_r[DIM_BITS-1:0];
              phase_nxt = PH_GAP_H;
            end else begin
              height_nxt = acc_r[DIM_BITS-1:0];
              phase_nxt  = PH_GAP_G;
            end
          end
          PH_PIXELS: begin
            // Pass the byte through and step the row-major position.
            pv_nxt   = 1'b1;
            pval_nxt = in_data_byte;
            if (col_inc >= {1'b0, width_r}) begin
              if (row_inc >= {1'b0, height_r}) begin
                last_nxt  = 1'b1;
                phase_nxt = PH_DONE;
              end
              col_nxt = '0;
              row_nxt = row_inc[DIM_BITS-1:0];
            end else begin
              col_nxt = col_inc[DIM_BITS-1:0];
            end
          end
          default: begin
            phase_nxt = PH_DONE;
          end
        endcase
      end
    end
  end

  // State and result registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_MAGIC0;
      mlen_r      <= 2'd0;
      mfirst_r    <= 8'd0;
      msecond_r   <= 8'd0;
      acc_r       <= '0;
      dend_r      <= 1'b0;
      width_r     <= '0;
      height_r    <= '0;
      gray_r      <= 8'd0;
      col_r       <= '0;
      row_r       <= '0;
      err_r       <= ERR_NONE;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        phase_r     <= phase_nxt;
        mlen_r      <= mlen_nxt;
        mfirst_r    <= mfirst_nxt;
        msecond_r   <= msecond_nxt;
        acc_r       <= acc_nxt;
        dend_r      <= dend_nxt;
        width_r     <= width_nxt;
        height_r    <= height_nxt;
        gray_r      <= gray_nxt;
        col_r       <= col_nxt;
        row_r       <= row_nxt;
        err_r       <= err_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload, loaded with each accepted item.
  always_ff @(posedge clk) begin
    if (accept) begin
      pv_r      <= pv_nxt;
      pval_r    <= pval_nxt;
      last_r    <= last_nxt;
      hd_r      <= hd_nxt;
      owidth_r  <= 16'(width_nxt);
      oheight_r <= 16'(height_nxt);
      ogray_r   <= gray_nxt;
      oerr_r    <= err_nxt;
      ofin_r    <= (phase_nxt == PH_DONE);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pixel_valid  = pv_r;
  assign out_pixel_value  = pval_r;
  assign out_last_pixel   = last_r;
  assign out_header_done  = hd_r;
  assign out_image_width  = owidth_r;
  assign out_image_height = oheight_r;
  assign out_max_gray     = ogray_r;
  assign out_error_code   = oerr_r;
  assign out_finished     = ofin_r;

endmodule

// File: rtl/pgmd_digit_acc.sv
// Saturating decimal accumulator step: acc * 10 + digit, capped at 2^DIM_BITS.
// Depends on nothing outside the module.
module pgmd_digit_acc #(
  parameter int DIM_BITS = 16
) (
  input  logic [DIM_BITS:0]   acc_cur,
  input  logic [3:0]          digit,
  output logic [DIM_BITS:0]   acc_new
);

  localparam int WIDE = DIM_BITS + 5;

  logic [WIDE-1:0] acc_ext;
  logic [WIDE-1:0] sum;
  logic [WIDE-1:0] cap;

  // Times ten is eight times plus two times.
  assign acc_ext = WIDE'(acc_cur);
  assign sum     = (acc_ext << 3) + (acc_ext << 1) + WIDE'(digit);
  assign cap     = WIDE'(1) << DIM_BITS;

  // Saturate so the value never wraps.
  assign acc_new = (sum > cap) ? cap[DIM_BITS:0] : sum[DIM_BITS:0];

endmodule

// File: rtl/pgmd_checker.sv
// Port-level checks for the stream deframer, bound to its top level.
// Depends on pgmd_pkg and pgm_binary_stream_deframer.
module pgmd_checker import pgmd_pkg::*; (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic                     out_pixel_valid,
  input logic                     out_pixel_value_any,
  input logic                     out_last_pixel,
  input logic                     out_header_done,
  input logic [PGMD_ERR_BITS-1:0] out_error_code,
  input logic                     out_finished
);

  logic fin_seen_r;

  // Remember that a finished result has been delivered.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_seen_r <= 1'b0;
    end else if (out_valid && out_ready && out_finished) begin
      fin_seen_r <= 1'b1;
    end
  end

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pixel_valid) &&
    $stable(out_pixel_value_any) && $stable(out_error_code) && $stable(out_finished))
    else $error("stalled result changed");

  // With no pending result the block must take an item.
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output register");

  // After a finished item, results carry no pulses and stay finished.
  a_after_fin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && fin_seen_r |-> out_finished && !out_pixel_valid && !out_header_done)
    else $error("activity after finish");

  // The last pixel is a pixel and ends the stream.
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_pixel |-> out_pixel_valid && out_finished)
    else $error("last pixel mark without pixel or finish");

  // Pixels flow only while no error is latched.
  a_pix_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_pixel_valid |-> out_error_code == ERR_NONE)
    else $error("pixel delivered with error latched");

endmodule

bind pgm_binary_stream_deframer pgmd_checker u_pgmd_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_ready            (in_ready),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .out_pixel_valid     (out_pixel_valid),
  .out_pixel_value_any (|out_pixel_value),
  .out_last_pixel      (out_last_pixel),
  .out_header_done     (out_header_done),
  .out_error_code      (out_error_code),
  .out_finished        (out_finished)
);

// File: dv/tb_pgm_binary_stream_deframer.sv
// Self-checking testbench for the binary gray map (P5) stream deframer.
// Depends on pgmd_pkg and the RTL of pgm_binary_stream_deframer; it reads no files.
module tb_pgm_binary_stream_deframer import pgmd_pkg::*;;

  // Character codes used to build the header.
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_VT      = 8'h0B;
  localparam logic [7:0] CH_FF      = 8'h0C;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_ALL_ONE = 8'hFF;

  localparam int unsigned DIM_MAX     = (1 << PGMD_DIM_BITS) - 1;
  localparam int unsigned ACC_CAP     = DIM_MAX + 1;
  localparam int unsigned GRAY_MAX    = 255;
  localparam int          CYCLE_LIMIT = 400000;

  // Parser stages of the predictor.
  typedef enum logic [3:0] {
    ST_MAGIC0, ST_MAGIC, ST_GAP_W, ST_NUM_W, ST_GAP_H, ST_NUM_H,
    ST_GAP_G, ST_NUM_G, ST_PIXELS, ST_DONE
  } parse_stage_t;

  // One result item as the block should present it.
  typedef struct packed {
    logic        pixel_valid;
    logic [7:0]  pixel_value;
    logic        last_pixel;
    logic        header_done;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic [7:0]  max_gray;
    pgmd_err_t   error_code;
    logic        finished;
  } frame_result_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [7:0]               in_data_byte = 8'h00;
  logic                     in_end_of_file = 1'b0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic                     out_pixel_valid;
  logic [7:0]               out_pixel_value;
  logic                     out_last_pixel;
  logic                     out_header_done;
  logic [15:0]              out_image_width;
  logic [15:0]              out_image_height;
  logic [7:0]               out_max_gray;
  logic [PGMD_ERR_BITS-1:0] out_error_code;
  logic                     out_finished;

  // Predictor state.
  parse_stage_t stage = ST_MAGIC0;
  logic [1:0]   magic_len = '0;
  logic [7:0]   magic_c0 = '0;
  logic [7:0]   magic_c1 = '0;
  logic [16:0]  acc = '0;
  logic         junk_seen = 1'b0;
  logic [15:0]  width_q = '0;
  logic [15:0]  height_q = '0;
  logic [7:0]   gray_q = '0;
  logic [15:0]  col_q = '0;
  logic [15:0]  row_q = '0;
  pgmd_err_t    err_q = ERR_NONE;

  // Scoreboard and run bookkeeping.
  frame_result_t expected_frames[$];
  frame_result_t oldest_frame;
  logic [7:0]    header_bytes[$];
  logic [7:0]    corner_pixels [0:6];
  int            send_idle_pct = 0;
  int            recv_stall_pct = 0;
  int            items_sent = 0;
  int            frames_checked = 0;
  int            mismatch_count = 0;
  int            cycle_count = 0;
  int unsigned   pixels_sent = 0;
  int unsigned   img_w, img_h, img_gray, pixels_to_send;
  bit            end_early, magic_upper;

  pgm_binary_stream_deframer i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_end_of_file   (in_end_of_file),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_pixel_valid  (out_pixel_valid),
    .out_pixel_value  (out_pixel_value),
    .out_last_pixel   (out_last_pixel),
    .out_header_done  (out_header_done),
    .out_image_width  (out_image_width),
    .out_image_height (out_image_height),
    .out_max_gray     (out_max_gray),
    .out_error_code   (out_error_code),
    .out_finished     (out_finished)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Stop a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // The receiver stalls at the rate of the current phase.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic bit is_space(input logic [7:0] b);
    return (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
  endfunction

  function automatic bit is_digit(input logic [7:0] b);
    return (b >= CH_ZERO) && (b <= CH_NINE);
  endfunction

  function automatic void latch_error(input pgmd_err_t code);
    err_q = code;
    stage = ST_DONE;
  endfunction

  // Advance the parser by one item and return the result it should produce.
  function automatic frame_result_t deframe_byte(input logic [7:0] b, input logic eof);
    frame_result_t r;
    int unsigned   v;
    int unsigned   limit;
    r = '0;
    if (stage != ST_DONE) begin
      if (eof) begin
        latch_error(ERR_EARLY_EOF);
      end else begin
        case (stage)
          ST_MAGIC0: begin
            if (is_space(b)) begin
              latch_error(ERR_LEAD_SPACE);
            end else begin
              magic_c0 = b;
              magic_len = 2'd1;
              stage = ST_MAGIC;
            end
          end
          ST_MAGIC: begin
            if (!is_space(b)) begin
              if (magic_len == 2'd1) magic_c1 = b;
              if (magic_len < 2'd3) magic_len = magic_len + 2'd1;
            end else if (magic_len == 2'd2 && magic_c1 == MAGIC_FIVE &&
                         (magic_c0 == MAGIC_UPPER_P || magic_c0 == MAGIC_LOWER_P)) begin
              stage = ST_GAP_W;
            end else begin
              latch_error(ERR_BAD_MAGIC);
            end
          end
          ST_GAP_W, ST_GAP_H, ST_GAP_G: begin
            // A token must open with a digit; whitespace is skipped.
            if (!is_space(b)) begin
              if (!is_digit(b)) begin
                latch_error(ERR_NON_DIGIT);
              end else begin
                acc = 17'(b - CH_ZERO);
                junk_seen = 1'b0;
                stage = parse_stage_t'(stage + 4'd1);
              end
            end
          end
          ST_NUM_W, ST_NUM_H, ST_NUM_G: begin
            limit = (stage == ST_NUM_G) ? GRAY_MAX : DIM_MAX;
            if (!is_space(b)) begin
              // The first non-digit ends the digits; the rest of the token is skipped.
              if (junk_seen || !is_digit(b)) begin
                junk_seen = 1'b1;
              end else begin
                v = acc * 10 + (b - CH_ZERO);
                acc = (v > ACC_CAP) ? 17'(ACC_CAP) : 17'(v);
              end
            end else if (acc > limit) begin
              latch_error(ERR_TOO_LARGE);
            end else if (stage == ST_NUM_W) begin
              width_q = acc[15:0];
              stage = ST_GAP_H;
            end else if (stage == ST_NUM_H) begin
              height_q = acc[15:0];
              stage = ST_GAP_G;
            end else begin
              gray_q = acc[7:0];
              r.header_done = 1'b1;
              col_q = '0;
              row_q = '0;
              stage = (width_q == 0 || height_q == 0) ? ST_DONE : ST_PIXELS;
            end
          end
          ST_PIXELS: begin
            r.pixel_valid = 1'b1;
            r.pixel_value = b;
            if (int'(col_q) + 1 >= int'(width_q)) begin
              if (int'(row_q) + 1 >= int'(height_q)) begin
                r.last_pixel = 1'b1;
                stage = ST_DONE;
              end
              col_q = '0;
              row_q = row_q + 16'd1;
            end else begin
              col_q = col_q + 16'd1;
            end
          end
          default: stage = ST_DONE;
        endcase
      end
    end
    r.image_width = width_q;
    r.image_height = height_q;
    r.max_gray = gray_q;
    r.error_code = err_q;
    r.finished = (stage == ST_DONE);
    return r;
  endfunction

  // Offer one item, wait for it to be taken, then record what it should yield.
  task automatic send_item(input logic [7:0] data_byte, input logic end_of_file);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data_byte <= data_byte;
    in_end_of_file <= end_of_file;
    do @(posedge clk); while (!in_ready);
    expected_frames.push_back(deframe_byte(data_byte, end_of_file));
    items_sent++;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  // Compare every taken result against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_frames.size() == 0) begin
        $error("result item arrived with no item outstanding");
        mismatch_count++;
      end else begin
        oldest_frame = expected_frames.pop_front();
        check_field("pixel_valid", 32'(oldest_frame.pixel_valid), 32'(out_pixel_valid));
        check_field("pixel_value", 32'(oldest_frame.pixel_value), 32'(out_pixel_value));
        check_field("last_pixel", 32'(oldest_frame.last_pixel), 32'(out_last_pixel));
        check_field("header_done", 32'(oldest_frame.header_done), 32'(out_header_done));
        check_field("image_width", 32'(oldest_frame.image_width), 32'(out_image_width));
        check_field("image_height", 32'(oldest_frame.image_height),
                    32'(out_image_height));
        check_field("max_gray", 32'(oldest_frame.max_gray), 32'(out_max_gray));
        check_field("error_code", 32'(oldest_frame.error_code), 32'(out_error_code));
        check_field("finished", 32'(oldest_frame.finished), 32'(out_finished));
        frames_checked++;
      end
    end
  end

  // Append the decimal digits of a value to the header.
  task automatic add_decimal(input int unsigned value);
    int unsigned scale;
    logic [7:0]  digit;
    scale = 1;
    while (scale * 10 <= value) scale = scale * 10;
    while (scale > 0) begin
      digit = 8'((value / scale) % 10);
      header_bytes.push_back(CH_ZERO + digit);
      scale = scale / 10;
    end
  endtask

  // Header with one of the two magic spellings, picked at random, every whitespace
  // kind, a leading zero and junk after the digits of a token.
  task automatic test_header();
    int unsigned pick;
    send_idle_pct = 13;
    recv_stall_pct = 13;
    header_bytes.push_back(magic_upper ? MAGIC_UPPER_P : MAGIC_LOWER_P);
    header_bytes.push_back(MAGIC_FIVE);
    header_bytes.push_back(CH_SPACE);
    header_bytes.push_back(CH_TAB);
    header_bytes.push_back(CH_ZERO);
    add_decimal(img_w);
    header_bytes.push_back(CH_ALL_ONE);
    header_bytes.push_back(CH_MINUS);
    header_bytes.push_back(CH_LF);
    header_bytes.push_back(CH_VT);
    add_decimal(img_h);
    header_bytes.push_back(CH_LOWER_A);
    header_bytes.push_back(CH_FF);
    header_bytes.push_back(CH_CR);
    header_bytes.push_back(CH_SPACE);
    add_decimal(img_gray);
    // The one whitespace after the maximum gray ends the header.
    pick = $urandom_range(5);
    header_bytes.push_back((pick == 5) ? CH_SPACE : CH_TAB + 8'(pick));
    foreach (header_bytes[i]) send_item(header_bytes[i], 1'b0);
  endtask

  // Pixel bytes in four idling phases; the first few are corner values.
  task automatic test_pixel_stream(input int unsigned count);
    int unsigned part;
    int unsigned chunk;
    int unsigned done;
    logic [7:0]  value;
    done = 0;
    for (part = 0; part < 4; part++) begin
      case (part)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 69; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 69; end
        default: begin send_idle_pct = 13; recv_stall_pct = 13; end
      endcase
      chunk = (part == 3) ? count - done : count / 4;
      repeat (chunk) begin
        value = 8'($urandom);
        send_item((pixels_sent < 7) ? corner_pixels[pixels_sent] : value, 1'b0);
        pixels_sent++;
      end
      done += chunk;
    end
  endtask

  // The sender holds off until every outstanding result has drained.
  task automatic test_drain_pause();
    in_valid <= 1'b0;
    recv_stall_pct = 69;
    while (expected_frames.size() != 0) @(posedge clk);
  endtask

  // An end-of-file mark before the last pixel latches the early-end error.
  task automatic test_stream_end();
    logic [7:0] value;
    value = 8'($urandom);
    if (end_early) send_item(value, 1'b1);
  endtask

  // Once finished, bytes and end-of-file marks leave the outputs unchanged.
  task automatic test_after_finish();
    logic [7:0] value;
    send_idle_pct = 69;
    recv_stall_pct = 69;
    repeat (24) begin
      value = 8'($urandom);
      send_item(value, $urandom_range(2) == 0);
    end
  endtask

  initial begin
    corner_pixels = '{8'h00, CH_ALL_ONE, CH_SPACE, CH_LF, MAGIC_FIVE, 8'h80, 8'h7F};
    magic_upper = 1'($urandom_range(1));
    end_early = 1'($urandom_range(1));
    img_w = $urandom_range(1, 48);
    img_h = (1100 + img_w - 1) / img_w;
    img_gray = $urandom_range(GRAY_MAX);
    pixels_to_send = img_w * img_h - (end_early ? $urandom_range(1, 5) : 0);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_header();
    test_pixel_stream(pixels_to_send / 2);
    test_drain_pause();
    test_pixel_stream(pixels_to_send - pixels_to_send / 2);
    test_stream_end();
    test_after_finish();

    // Let the last results drain, then keep watching for stray results.
    in_valid <= 1'b0;
    recv_stall_pct = 0;
    while (expected_frames.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Image %0dx%0d, max gray %0d, %s ending: %0d items sent, %0d results compared.",
             img_w, img_h, img_gray, end_early ? "early end-of-file" : "complete",
             items_sent, frames_checked);
    $display("Mismatches found: %0d.", mismatch_count);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/pgmd_pkg.sv
rtl/pgmd_digit_acc.sv
rtl/pgm_binary_stream_deframer.sv
rtl/pgmd_checker.sv
dv/tb_pgm_binary_stream_deframer.sv
